>>> rtl/core/nwlt_pkg.sv
// ----------------------------------------------------------------------------
// nwlt_pkg: shared types and constants of the record lock table
// Sizes of the lock store and request queue, opcodes, status codes, and the
// request, command and response structs.
// ----------------------------------------------------------------------------
`default_nettype none

package nwlt_pkg;

	localparam int LOCK_ENTRIES = 64;
	localparam int IDX_W        = $clog2(LOCK_ENTRIES);
	localparam int KEY_W        = 44;
	localparam int TXN_W        = 16;
	localparam int ENTRY_W      = KEY_W + TXN_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LOCK_ENTRIES - 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

	localparam logic [1:0] OP_ACQUIRE = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	localparam logic [1:0] STS_DONE      = 2'd0;
	localparam logic [1:0] STS_CONFLICT  = 2'd1;
	localparam logic [1:0] STS_FULL      = 2'd2;
	localparam logic [1:0] STS_NOT_FOUND = 2'd3;

	typedef enum logic [1:0] {
		CL_ACQUIRE,
		CL_RELEASE,
		CL_QUERY,
		CL_IGNORE
	} cmd_class_t;

	typedef enum logic {
		BK_IDLE,
		BK_SCAN
	} bk_state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  table_id;
		logic [23:0] record_page;
		logic [11:0] record_slot;
		logic [15:0] txn_id;
	} req_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] status;
		logic       held;
	} rsp_t;

	typedef struct packed {
		cmd_class_t       cls;
		logic [KEY_W-1:0] key;
		logic [TXN_W-1:0] txn;
	} cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TXN_W-1:0] holder;
	} lock_entry_t;

endpackage

`default_nettype wire

>>> rtl/core/nwlt_ram.sv
// ----------------------------------------------------------------------------
// nwlt_ram: generic single-write, single-read RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nwlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/nwlt_front.sv
// ----------------------------------------------------------------------------
// nwlt_front: request intake and classification
// Takes requests, builds the lock key, classifies the opcode and holds the
// commands in a short queue for the lookup engine.
// ----------------------------------------------------------------------------
`default_nettype none

module nwlt_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire nwlt_pkg::req_t  req,
	output logic                 busy,
	output logic                 cmd_vld,
	output nwlt_pkg::cmd_t       cmd,
	input  wire logic            pop
);

	nwlt_pkg::cmd_t                    new_cmd;
	nwlt_pkg::cmd_t                    fifo_q [nwlt_pkg::QUEUE_DEPTH];
	logic [nwlt_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [nwlt_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [nwlt_pkg::QCNT_W-1:0]       cnt_q;
	logic                              push;

	always_comb begin
		new_cmd.key = {req.table_id, req.record_page, req.record_slot};
		new_cmd.txn = req.txn_id;
		unique case (req.opcode)
			nwlt_pkg::OP_ACQUIRE: new_cmd.cls = nwlt_pkg::CL_ACQUIRE;
			nwlt_pkg::OP_RELEASE: new_cmd.cls = nwlt_pkg::CL_RELEASE;
			nwlt_pkg::OP_QUERY:   new_cmd.cls = nwlt_pkg::CL_QUERY;
			default:              new_cmd.cls = nwlt_pkg::CL_IGNORE;
		endcase
	end

	assign busy    = (cnt_q == nwlt_pkg::QCNT_FULL);
	assign push    = start && !busy;
	assign cmd_vld = (cnt_q != '0);
	assign cmd     = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == nwlt_pkg::QPTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == nwlt_pkg::QPTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/nwlt_back.sv
// ----------------------------------------------------------------------------
// nwlt_back: lock table lookup engine
// Walks the key store one entry per cycle looking for the key and the
// lowest free entry, then applies the acquire, release or query.
// ----------------------------------------------------------------------------
`default_nettype none

module nwlt_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_vld,
	input  wire nwlt_pkg::cmd_t  cmd,
	output logic                 pop,
	output logic                 done,
	output nwlt_pkg::rsp_t       rsp
);

	nwlt_pkg::bk_state_t              state_q, state_d;
	nwlt_pkg::cmd_t                   cur_q;
	logic [nwlt_pkg::LOCK_ENTRIES-1:0] valid_q;
	logic [nwlt_pkg::IDX_W-1:0]       idx_q;
	logic                             issue_done_q;
	logic                             chk_vld_s1;
	logic [nwlt_pkg::IDX_W-1:0]       chk_idx_s1;
	logic                             free_fnd_q;
	logic [nwlt_pkg::IDX_W-1:0]       free_idx_q;
	logic                             done_q;
	nwlt_pkg::rsp_t                   rsp_q;

	logic [nwlt_pkg::ENTRY_W-1:0]     rd_data;
	nwlt_pkg::lock_entry_t            rd_entry;
	nwlt_pkg::lock_entry_t            wr_entry;
	logic                             cur_valid;
	logic                             hit_now;
	logic                             last;
	logic                             finish;
	logic                             free_any;
	logic [nwlt_pkg::IDX_W-1:0]       free_sel;
	logic                             issuing;
	logic                             start_scan;
	logic                             rsp_vld_d;
	nwlt_pkg::rsp_t                   rsp_d;
	logic                             ram_we;
	logic                             set_vld;
	logic                             clr_vld;
	logic [nwlt_pkg::IDX_W-1:0]       upd_idx;

	assign rd_entry = nwlt_pkg::lock_entry_t'(rd_data);
	assign wr_entry = '{key: cur_q.key, holder: cur_q.txn};

	nwlt_ram #(
		.WIDTH(nwlt_pkg::ENTRY_W),
		.DEPTH(nwlt_pkg::LOCK_ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(upd_idx),
		.wdata(wr_entry),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	// Keys are unique among valid entries, so the first hit is the only one.
	assign cur_valid = valid_q[chk_idx_s1];
	assign hit_now   = chk_vld_s1 && cur_valid && (rd_entry.key == cur_q.key);
	assign last      = (chk_idx_s1 == nwlt_pkg::LAST_IDX);
	assign finish    = (state_q == nwlt_pkg::BK_SCAN) && chk_vld_s1 && (hit_now || last);
	assign free_any  = free_fnd_q || !cur_valid;
	assign free_sel  = free_fnd_q ? free_idx_q : chk_idx_s1;
	assign issuing   = (state_q == nwlt_pkg::BK_SCAN) && !issue_done_q && !finish;

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		start_scan = 1'b0;
		rsp_vld_d  = 1'b0;
		rsp_d      = '{ok: 1'b0, status: nwlt_pkg::STS_DONE, held: 1'b0};
		ram_we     = 1'b0;
		set_vld    = 1'b0;
		clr_vld    = 1'b0;
		upd_idx    = chk_idx_s1;
		unique case (state_q)
			nwlt_pkg::BK_IDLE: begin
				if (cmd_vld) begin
					pop = 1'b1;
					if (cmd.cls == nwlt_pkg::CL_IGNORE) begin
						rsp_vld_d = 1'b1;
					end else begin
						start_scan = 1'b1;
						state_d    = nwlt_pkg::BK_SCAN;
					end
				end
			end
			nwlt_pkg::BK_SCAN: begin
				if (finish) begin
					state_d   = nwlt_pkg::BK_IDLE;
					rsp_vld_d = 1'b1;
					unique case (cur_q.cls)
						nwlt_pkg::CL_ACQUIRE: begin
							if (hit_now) begin
								if (rd_entry.holder == cur_q.txn) begin
									rsp_d.ok = 1'b1;
								end else begin
									rsp_d.status = nwlt_pkg::STS_CONFLICT;
								end
							end else if (free_any) begin
								ram_we   = 1'b1;
								set_vld  = 1'b1;
								upd_idx  = free_sel;
								rsp_d.ok = 1'b1;
							end else begin
								rsp_d.status = nwlt_pkg::STS_FULL;
							end
						end
						nwlt_pkg::CL_RELEASE: begin
							if (hit_now) begin
								clr_vld  = 1'b1;
								rsp_d.ok = 1'b1;
							end else begin
								rsp_d.status = nwlt_pkg::STS_NOT_FOUND;
							end
						end
						nwlt_pkg::CL_QUERY: begin
							rsp_d.held = hit_now;
						end
						nwlt_pkg::CL_IGNORE: begin
							rsp_d.held = 1'b0;
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= nwlt_pkg::BK_IDLE;
			valid_q      <= '0;
			idx_q        <= '0;
			issue_done_q <= 1'b0;
			chk_vld_s1   <= 1'b0;
			free_fnd_q   <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q    <= state_d;
			done_q     <= rsp_vld_d;
			chk_vld_s1 <= issuing;
			if (start_scan) begin
				idx_q        <= '0;
				issue_done_q <= 1'b0;
				free_fnd_q   <= 1'b0;
			end else begin
				if (issuing) begin
					idx_q        <= idx_q + 1'b1;
					issue_done_q <= (idx_q == nwlt_pkg::LAST_IDX);
				end
				if (chk_vld_s1 && !cur_valid) begin
					free_fnd_q <= 1'b1;
				end
			end
			if (set_vld) begin
				valid_q[upd_idx] <= 1'b1;
			end
			if (clr_vld) begin
				valid_q[upd_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= cmd;
		end
		if (issuing) begin
			chk_idx_s1 <= idx_q;
		end
		if (chk_vld_s1 && !cur_valid && !free_fnd_q) begin
			free_idx_q <= chk_idx_s1;
		end
		if (rsp_vld_d) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

>>> rtl/core/no_wait_record_lock_table.sv
// ----------------------------------------------------------------------------
// no_wait_record_lock_table: exclusive record lock table, no-wait rule
// Acquire, release and query of record locks keyed by table, page and slot.
//
//   channel   | signals            | handshake
//   ----------+--------------------+------------------------------------
//   request   | start, busy, req   | taken when start is high, busy low
//   result    | done, rsp          | one-cycle strobe, cannot be held off
//
// An unused opcode gives its result in the cycle after it leaves the queue.
// Other requests walk the key memory one entry per cycle through its single read
// port: a walk stops at the entry that holds the key, or after the last entry on a
// miss, and the result is registered after the check. Up to QUEUE_DEPTH requests
// wait in the queue; busy is high while it is full. Reset empties the table
// at once through the valid flags, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module no_wait_record_lock_table (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire nwlt_pkg::req_t  req,
	output logic                 done,
	output nwlt_pkg::rsp_t       rsp
);

	logic            cmd_vld;
	nwlt_pkg::cmd_t  cmd;
	logic            pop;

	nwlt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.cmd_vld(cmd_vld),
		.cmd    (cmd),
		.pop    (pop)
	);

	nwlt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_vld(cmd_vld),
		.cmd    (cmd),
		.pop    (pop),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

>>> rtl/core/nwlt_checker.sv
// ----------------------------------------------------------------------------
// nwlt_checker: port-level checks of the record lock table
// Checks response consistency, that busy rises only after a request, and that done stays low right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module nwlt_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            start,
	input wire logic            busy,
	input wire logic            done,
	input wire nwlt_pkg::rsp_t  rsp
);

	// Only a query reports a held key, and it never grants or fails.
	a_held_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.held |-> !rsp.ok && (rsp.status == nwlt_pkg::STS_DONE))
		else $error("held result carries ok or a failure status");

	a_ok_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.ok |-> (rsp.status == nwlt_pkg::STS_DONE))
		else $error("granted result carries a failure status");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != nwlt_pkg::STS_DONE) |-> !rsp.ok && !rsp.held)
		else $error("failed result has ok or held set");

	// The queue fills only through a request taken in the cycle before.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	// Nothing is pending right after reset, so no result may appear.
	a_no_done_from_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> !done)
		else $error("result strobe right after reset");

endmodule

bind no_wait_record_lock_table nwlt_checker u_nwlt_checker (.*);

`default_nettype wire
